// ----- src/resp_pkg.sv -----
package resp_pkg;

   // CORDIC datapath width (Q2.30 with headroom) and default step count
   localparam int CW                = 34;
   localparam int CORDIC_STEPS_DEF  = 24;
   // quotient bits of semi_major * 2^16 / perturb_amp
   localparam int DIV_STAGES        = 47;

   // configuration register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] REG_PERTURB_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PERTURB_AMP   = 2'd1;

   localparam logic [31:0] CORDIC_K = 32'h26DD3B6A;
   localparam logic [31:0] HALF_TURN = 32'h80000000;

   // arctangent of 2^-i in binary-angle units
   localparam logic [31:0] ATAN_TAB [32] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
      32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
      32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
      32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
      32'h00000001, 32'h00000000
   };

   typedef struct packed {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [CW-1:0] z;
      logic                 flip;
   } cdc_type;

   typedef struct packed {
      logic [31:0]             rem;
      logic [DIV_STAGES-1:0]   dq;
   } div_type;

   typedef struct packed {
      cdc_type              orb;
      cdc_type              tlt;
      cdc_type              prt;
      div_type              dv;
      logic signed [31:0]   cx;
      logic signed [31:0]   cy;
      logic [30:0]          a;
      logic [30:0]          b;
      logic                 pen;
   } stage_type;

   // fold into a quarter turn either way and load the CORDIC start vector
   function automatic cdc_type cdc_init(logic [31:0] ang);
      cdc_type     r;
      logic        flip;
      logic [31:0] a;
      flip   = (ang[31:30] == 2'b01) || (ang[31:30] == 2'b10);
      a      = flip ? ang - HALF_TURN : ang;
      r.x    = {{(CW-32){1'b0}}, CORDIC_K};
      r.y    = '0;
      r.z    = {{(CW-32){a[31]}}, a};
      r.flip = flip;
      return r;
   endfunction

   // one rotation-mode micro-rotation
   function automatic cdc_type cdc_step(cdc_type c, logic [4:0] i);
      cdc_type              r;
      logic signed [CW-1:0] dx;
      logic signed [CW-1:0] dy;
      logic signed [CW-1:0] at;
      dx = $signed(c.y) >>> i;
      dy = $signed(c.x) >>> i;
      at = $signed({{(CW-32){1'b0}}, ATAN_TAB[i]});
      r  = c;
      if (!c.z[CW-1]) begin
         r.x = c.x - dx;
         r.y = c.y + dy;
         r.z = c.z - at;
      end else begin
         r.x = c.x + dx;
         r.y = c.y - dy;
         r.z = c.z + at;
      end
      return r;
   endfunction

   // one restoring-division bit
   function automatic div_type div_step(div_type d, logic [31:0] den);
      div_type     r;
      logic [32:0] t;
      logic        qb;
      t  = {d.rem, d.dq[DIV_STAGES-1]};
      qb = (t >= {1'b0, den});
      r.rem = qb ? 32'(t - {1'b0, den}) : t[31:0];
      r.dq  = {d.dq[DIV_STAGES-2:0], qb};
      return r;
   endfunction

   function automatic logic signed [31:0] sat32(logic signed [51:0] v);
      logic signed [31:0] r;
      if (v > 52'sd2147483647)
         r = 32'sh7FFFFFFF;
      else if (v < -52'sd2147483648)
         r = 32'sh80000000;
      else
         r = v[31:0];
      return r;
   endfunction

endpackage

// ----- src/rotated_ellipse_star_position.sv -----
// Channel   Direction  Ports
// req       in         req_valid / req_ready, orbit and tilt angle, center, semi-axes
// rsp       out        rsp_valid / rsp_ready, pos_x, pos_y
// csr       in         csr_we, csr_index, csr_wdata (write only)
//
// One star per cycle unless a result waits on rsp_ready. Stages: an input stage, 47 stages
// that each produce one quotient bit and (the first CORDIC_STEPS of them) one micro-rotation
// of the three CORDICs, four multiply/round stages and the output register.
// Synchronous reset clears the valid bits and the two registers.
// The whole pipeline holds while a result waits on rsp_ready; no beat is lost or repeated.
module rotated_ellipse_star_position #(
   parameter int CORDIC_STEPS = resp_pkg::CORDIC_STEPS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [31:0]                        req_orbit_angle,
   input  logic [31:0]                        req_tilt_angle,
   input  logic signed [31:0]                 req_center_x,
   input  logic signed [31:0]                 req_center_y,
   input  logic [30:0]                        req_semi_major,
   input  logic [30:0]                        req_semi_minor,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [31:0]                 rsp_pos_x,
   output logic signed [31:0]                 rsp_pos_y,
   input  logic                               csr_we,
   input  logic [resp_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [31:0]                        csr_wdata
);
   import resp_pkg::*;

   localparam int NST = DIV_STAGES;
   localparam logic signed [81:0] RND = 82'sd536870912;   // 2^29

   logic [7:0]  perturb_count_ff;
   logic [31:0] perturb_amp_ff;
   logic        adv;

   stage_type   pipe_ff  [0:NST];
   logic        pipe_vld_ff [0:NST];
   stage_type   pipe_in;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         perturb_count_ff <= '0;
         perturb_amp_ff   <= '0;
      end else if (csr_we) begin
         if (csr_index == REG_PERTURB_COUNT)
            perturb_count_ff <= csr_wdata[7:0];
         else if (csr_index == REG_PERTURB_AMP)
            perturb_amp_ff <= csr_wdata;
      end
   end

   // global advance: move whenever the output slot is free or being taken
   logic out_vld_ff;
   assign adv       = !out_vld_ff || rsp_ready;
   assign req_ready = adv;

   // input stage: fold angles, form perturbation angle, seed divider
   logic [31:0] pang;
   always_comb begin
      pang           = 32'(req_orbit_angle * {23'd0, perturb_count_ff, 1'b0});
      pipe_in.orb    = cdc_init(req_orbit_angle);
      pipe_in.tlt    = cdc_init(req_tilt_angle);
      pipe_in.prt    = cdc_init(pang);
      pipe_in.dv.rem = '0;
      pipe_in.dv.dq  = {req_semi_major, 16'd0};
      pipe_in.cx     = req_center_x;
      pipe_in.cy     = req_center_y;
      pipe_in.a      = req_semi_major;
      pipe_in.b      = req_semi_minor;
      pipe_in.pen    = (perturb_count_ff != 8'd0) && (perturb_amp_ff != 32'd0);
   end

   always_ff @(posedge clock) begin
      if (adv)
         pipe_ff[0] <= pipe_in;
   end

   // CORDIC and divider stages
   for (genvar k = 1; k <= NST; k++) begin : g_stage
      stage_type nxt_in;
      always_comb begin
         nxt_in    = pipe_ff[k-1];
         nxt_in.dv = div_step(pipe_ff[k-1].dv, perturb_amp_ff);
         if (k - 1 < CORDIC_STEPS) begin
            nxt_in.orb = cdc_step(pipe_ff[k-1].orb, 5'(k - 1));
            nxt_in.tlt = cdc_step(pipe_ff[k-1].tlt, 5'(k - 1));
            nxt_in.prt = cdc_step(pipe_ff[k-1].prt, 5'(k - 1));
         end
      end
      always_ff @(posedge clock) begin
         if (adv)
            pipe_ff[k] <= nxt_in;
      end
   end

   // valid bits
   logic m1_vld_ff, m2_vld_ff, m3_vld_ff, m4_vld_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j <= NST; j++)
            pipe_vld_ff[j] <= 1'b0;
         m1_vld_ff  <= 1'b0;
         m2_vld_ff  <= 1'b0;
         m3_vld_ff  <= 1'b0;
         m4_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         pipe_vld_ff[0] <= req_valid;
         for (int j = 1; j <= NST; j++)
            pipe_vld_ff[j] <= pipe_vld_ff[j-1];
         m1_vld_ff  <= pipe_vld_ff[NST];
         m2_vld_ff  <= m1_vld_ff;
         m3_vld_ff  <= m2_vld_ff;
         m4_vld_ff  <= m3_vld_ff;
         out_vld_ff <= m4_vld_ff;
      end
   end

   // M1: unfold CORDIC outputs, first products
   logic signed [CW-1:0] co, so, ct, st, cp, sp;
   always_comb begin
      co = pipe_ff[NST].orb.flip ? -pipe_ff[NST].orb.x : pipe_ff[NST].orb.x;
      so = pipe_ff[NST].orb.flip ? -pipe_ff[NST].orb.y : pipe_ff[NST].orb.y;
      ct = pipe_ff[NST].tlt.flip ? -pipe_ff[NST].tlt.x : pipe_ff[NST].tlt.x;
      st = pipe_ff[NST].tlt.flip ? -pipe_ff[NST].tlt.y : pipe_ff[NST].tlt.y;
      cp = pipe_ff[NST].prt.flip ? -pipe_ff[NST].prt.x : pipe_ff[NST].prt.x;
      sp = pipe_ff[NST].prt.flip ? -pipe_ff[NST].prt.y : pipe_ff[NST].prt.y;
   end

   logic signed [65:0]   m1_ua_ff, m1_ub_ff, m1_psh_ff, m1_psl_ff, m1_pch_ff, m1_pcl_ff;
   logic signed [CW-1:0] m1_ct_ff, m1_st_ff;
   logic signed [31:0]   m1_cx_ff, m1_cy_ff;
   logic                 m1_pen_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         m1_ua_ff  <= $signed({1'b0, pipe_ff[NST].a}) * co;
         m1_ub_ff  <= $signed({1'b0, pipe_ff[NST].b}) * so;
         m1_psh_ff <= $signed({1'b0, pipe_ff[NST].dv.dq[46:16]}) * sp;
         m1_psl_ff <= $signed({1'b0, pipe_ff[NST].dv.dq[15:0]}) * sp;
         m1_pch_ff <= $signed({1'b0, pipe_ff[NST].dv.dq[46:16]}) * cp;
         m1_pcl_ff <= $signed({1'b0, pipe_ff[NST].dv.dq[15:0]}) * cp;
         m1_ct_ff  <= ct;
         m1_st_ff  <= st;
         m1_cx_ff  <= pipe_ff[NST].cx;
         m1_cy_ff  <= pipe_ff[NST].cy;
         m1_pen_ff <= pipe_ff[NST].pen;
      end
   end

   // M2: round orbit terms, assemble perturbation terms
   logic signed [81:0] ua_w, ub_w, px_w, py_w;
   always_comb begin
      ua_w = ({{16{m1_ua_ff[65]}}, m1_ua_ff} + RND) >>> 30;
      ub_w = ({{16{m1_ub_ff[65]}}, m1_ub_ff} + RND) >>> 30;
      px_w = (({{16{m1_psh_ff[65]}}, m1_psh_ff} <<< 16)
              + {{16{m1_psl_ff[65]}}, m1_psl_ff} + RND) >>> 30;
      py_w = (({{16{m1_pch_ff[65]}}, m1_pch_ff} <<< 16)
              + {{16{m1_pcl_ff[65]}}, m1_pcl_ff} + RND) >>> 30;
   end

   logic signed [35:0]   m2_ua_ff, m2_ub_ff;
   logic signed [49:0]   m2_px_ff, m2_py_ff;
   logic signed [CW-1:0] m2_ct_ff, m2_st_ff;
   logic signed [31:0]   m2_cx_ff, m2_cy_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         m2_ua_ff <= ua_w[35:0];
         m2_ub_ff <= ub_w[35:0];
         m2_px_ff <= m1_pen_ff ? px_w[49:0] : '0;
         m2_py_ff <= m1_pen_ff ? py_w[49:0] : '0;
         m2_ct_ff <= m1_ct_ff;
         m2_st_ff <= m1_st_ff;
         m2_cx_ff <= m1_cx_ff;
         m2_cy_ff <= m1_cy_ff;
      end
   end

   // M3: tilt rotation products
   logic signed [69:0] m3_ac_ff, m3_as_ff, m3_bc_ff, m3_bs_ff;
   logic signed [49:0] m3_px_ff, m3_py_ff;
   logic signed [31:0] m3_cx_ff, m3_cy_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         m3_ac_ff <= m2_ua_ff * m2_ct_ff;
         m3_as_ff <= m2_ua_ff * m2_st_ff;
         m3_bc_ff <= m2_ub_ff * m2_ct_ff;
         m3_bs_ff <= m2_ub_ff * m2_st_ff;
         m3_px_ff <= m2_px_ff;
         m3_py_ff <= m2_py_ff;
         m3_cx_ff <= m2_cx_ff;
         m3_cy_ff <= m2_cy_ff;
      end
   end

   // M4: round tilt products
   logic signed [69:0] ac_w, as_w, bc_w, bs_w;
   always_comb begin
      ac_w = (m3_ac_ff + 70'sd536870912) >>> 30;
      as_w = (m3_as_ff + 70'sd536870912) >>> 30;
      bc_w = (m3_bc_ff + 70'sd536870912) >>> 30;
      bs_w = (m3_bs_ff + 70'sd536870912) >>> 30;
   end

   logic signed [39:0] m4_ac_ff, m4_as_ff, m4_bc_ff, m4_bs_ff;
   logic signed [49:0] m4_px_ff, m4_py_ff;
   logic signed [31:0] m4_cx_ff, m4_cy_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         m4_ac_ff <= ac_w[39:0];
         m4_as_ff <= as_w[39:0];
         m4_bc_ff <= bc_w[39:0];
         m4_bs_ff <= bs_w[39:0];
         m4_px_ff <= m3_px_ff;
         m4_py_ff <= m3_py_ff;
         m4_cx_ff <= m3_cx_ff;
         m4_cy_ff <= m3_cy_ff;
      end
   end

   // output: sum and saturate
   logic signed [51:0] x_sum, y_sum;
   logic signed [31:0] pos_x_ff, pos_y_ff;
   always_comb begin
      x_sum = 52'(m4_cx_ff) + 52'(m4_ac_ff) + 52'(m4_bs_ff) + 52'(m4_px_ff);
      y_sum = 52'(m4_cy_ff) - 52'(m4_as_ff) + 52'(m4_bc_ff) + 52'(m4_py_ff);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pos_x_ff <= sat32(x_sum);
         pos_y_ff <= sat32(y_sum);
      end
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_pos_x = pos_x_ff;
   assign rsp_pos_y = pos_y_ff;

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
   import resp_pkg::*;

   // indexes that decode to no register; writes to them must be ignored
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_2 = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_3 = 2'd3;
   localparam int DRAIN_CYCLES = 60;

   typedef struct {
      logic [31:0]        orbit;
      logic [31:0]        tilt;
      logic signed [31:0] cx;
      logic signed [31:0] cy;
      logic [30:0]        a;
      logic [30:0]        b;
   } star_type;

   typedef struct {
      logic signed [31:0] x;
      logic signed [31:0] y;
   } pos_type;

   typedef struct {
      star_type s;
      bit       typed;
      pos_type  p;
   } star_row_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [31:0]        req_orbit_angle;
   logic [31:0]        req_tilt_angle;
   logic signed [31:0] req_center_x;
   logic signed [31:0] req_center_y;
   logic [30:0]        req_semi_major;
   logic [30:0]        req_semi_minor;
   logic               rsp_valid;
   logic               rsp_ready;
   logic signed [31:0] rsp_pos_x;
   logic signed [31:0] rsp_pos_y;
   logic               csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [31:0]        csr_wdata;

   rotated_ellipse_star_position u_dut (.*);

   // 8 ns clock
   always begin
      clock = 1'b1; #4;
      clock = 1'b0; #4;
   end

   // shadow copy of the perturbation registers
   logic [7:0]  shadow_count;
   logic [31:0] shadow_amp;

   pos_type      pending_pos[$];
   int           mismatches;
   int           send_idle_pct;
   int           recv_stall_pct;
   star_row_type directed_rows[$];

   // ---------------- position predictor ----------------

   // rotation-mode CORDIC, folded to a quarter turn, Q2.30 out
   task automatic cordic_sincos(input logic [31:0] ang, output longint s, output longint c);
      logic        flip;
      logic [31:0] folded;
      longint      x, y, z, dx, dy;
      flip   = (ang[31:30] == 2'b01) || (ang[31:30] == 2'b10);
      folded = flip ? ang - 32'h80000000 : ang;
      z      = longint'($signed(folded));
      x      = longint'(CORDIC_K);
      y      = 0;
      for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x = x - dx; y = y + dy; z = z - longint'(ATAN_TAB[i]);
         end else begin
            x = x + dx; y = y - dy; z = z + longint'(ATAN_TAB[i]);
         end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endtask

   // length times Q2.30, rounded half up to Q16.16
   function automatic longint scale_q30(longint v, longint c);
      return (v * c + (longint'(1) <<< 29)) >>> 30;
   endfunction

   // same rounding for a 47-bit quotient, split so nothing overflows
   function automatic longint scale_q30_wide(longint p, longint c);
      longint ph, pl, r, hi, lo;
      ph = p >>> 16;
      pl = p & 64'hFFFF;
      r  = ph * c;
      hi = r >>> 14;
      lo = r - hi * (longint'(1) <<< 14);
      return hi + ((lo * (longint'(1) <<< 16) + pl * c + (longint'(1) <<< 29)) >>> 30);
   endfunction

   function automatic logic signed [31:0] clamp32(longint v);
      if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   task automatic predict_position(input star_type s, output pos_type r);
      longint so, co, st, ct, ua, ub, x, y, p, sp, cp;
      logic [63:0] num;
      logic [31:0] pa;
      cordic_sincos(s.orbit, so, co);
      cordic_sincos(s.tilt, st, ct);
      ua = scale_q30(longint'(s.a), co);
      ub = scale_q30(longint'(s.b), so);
      x  = longint'(s.cx) + scale_q30(ua, ct) + scale_q30(ub, st);
      y  = longint'(s.cy) - scale_q30(ua, st) + scale_q30(ub, ct);
      if (shadow_count != 0 && shadow_amp != 0) begin
         num = {33'd0, s.a} << 16;
         p   = longint'(num / {32'd0, shadow_amp});
         pa  = 32'(64'(s.orbit) * 64'd2 * 64'(shadow_count));
         cordic_sincos(pa, sp, cp);
         x = x + scale_q30_wide(p, sp);
         y = y + scale_q30_wide(p, cp);
      end
      r.x = clamp32(x);
      r.y = clamp32(y);
   endtask

   // ---------------- stimulus ----------------

   task automatic send_star(input star_type s, input bit typed, input pos_type p);
      pos_type expct;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_orbit_angle <= s.orbit;
      req_tilt_angle  <= s.tilt;
      req_center_x    <= s.cx;
      req_center_y    <= s.cy;
      req_semi_major  <= s.a;
      req_semi_minor  <= s.b;
      if (typed) expct = p;
      else predict_position(s, expct);
      do @(posedge clock); while (!req_ready);
      pending_pos.push_back(expct);
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == REG_PERTURB_COUNT) shadow_count = val[7:0];
      else if (idx == REG_PERTURB_AMP) shadow_amp = val;
      @(negedge clock);
   endtask

   // let the pipeline empty before touching the registers
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_pos.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   function automatic star_type random_star();
      star_type s;
      s.orbit = $urandom;
      s.tilt  = $urandom;
      case ($urandom_range(3))
         0: begin
            s.cx = $urandom; s.cy = $urandom;
            s.a  = 31'($urandom); s.b = 31'($urandom);
         end
         1: begin
            s.cx = $urandom_range(32'h00FFFFFF) - 32'h00800000;
            s.cy = $urandom_range(32'h00FFFFFF) - 32'h00800000;
            s.a  = 31'($urandom_range(32'h3FFFFF));
            s.b  = 31'($urandom_range(32'h3FFFFF));
         end
         default: begin
            s.cx = $urandom_range(32'h1FFFFFFF) - 32'h10000000;
            s.cy = $urandom_range(32'h1FFFFFFF) - 32'h10000000;
            s.a  = 31'($urandom_range(32'h0FFFFFFF));
            s.b  = 31'($urandom_range(32'h0FFFFFFF));
            if (s.b > s.a) s.b = s.a;
         end
      endcase
      return s;
   endfunction

   function automatic star_row_type row(logic [31:0] o, logic [31:0] t, logic signed [31:0] cx,
                                        logic signed [31:0] cy, logic [30:0] a, logic [30:0] b,
                                        bit typed);
      star_row_type r;
      r.s = '{o, t, cx, cy, a, b};
      r.typed = typed;
      // with both axes zero the star sits on the centre
      r.p = '{cx, cy};
      return r;
   endfunction

   task automatic set_idling(int mode);
      case (mode % 4)
         0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
         2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
         default: begin send_idle_pct = 17; recv_stall_pct = 17; end
      endcase
   endtask

   // receiver back-pressure
   always @(negedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // result checker
   always @(posedge clock) begin
      pos_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_pos.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected beat: x=%h y=%h", rsp_pos_x, rsp_pos_y);
         end else begin
            want = pending_pos.pop_front();
            if (rsp_pos_x !== want.x || rsp_pos_y !== want.y) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("position mismatch: expected x=%h y=%h, got x=%h y=%h",
                           want.x, want.y, rsp_pos_x, rsp_pos_y);
            end
         end
      end
   end

   initial begin
      #20ms;
      $display("FAIL rotated_ellipse_star_position");
      $finish;
   end

   initial begin
      star_type s;
      pos_type  none;
      logic [7:0]  counts[6];
      logic [31:0] amps[6];
      mismatches = 0;
      shadow_count = '0;
      shadow_amp = '0;
      none = '{0, 0};
      set_idling(0);
      reset = 1'b1;
      req_valid = 1'b0;
      req_orbit_angle = '0;
      req_tilt_angle = '0;
      req_center_x = '0;
      req_center_y = '0;
      req_semi_major = '0;
      req_semi_minor = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: centre extremes, axis extremes, quadrant folds, saturation
      directed_rows.push_back(row(32'h0, 32'h0, 32'sh0, 32'sh0, 31'h0, 31'h0, 1));
      directed_rows.push_back(row(32'hFFFFFFFF, 32'hFFFFFFFF, 32'sh7FFFFFFF, 32'sh80000000,
                                  31'h0, 31'h0, 1));
      directed_rows.push_back(row(32'h40000000, 32'h80000000, 32'sh80000000, 32'sh7FFFFFFF,
                                  31'h0, 31'h0, 1));
      directed_rows.push_back(row(32'h0, 32'h0, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
                                  31'h7FFFFFFF, 31'h7FFFFFFF, 0));
      directed_rows.push_back(row(32'h80000000, 32'h0, 32'sh80000000, 32'sh80000000,
                                  31'h7FFFFFFF, 31'h7FFFFFFF, 0));
      directed_rows.push_back(row(32'h40000000, 32'h40000000, 32'sh0, 32'sh0,
                                  31'h7FFFFFFF, 31'h7FFFFFFF, 0));
      directed_rows.push_back(row(32'hC0000000, 32'hC0000000, 32'sh00010000, 32'sh0,
                                  31'h00030000, 31'h00010000, 0));
      directed_rows.push_back(row(32'h3FFFFFFF, 32'h7FFFFFFF, 32'sh0, 32'sh0,
                                  31'h00010000, 31'h00010000, 0));
      directed_rows.push_back(row(32'hBFFFFFFF, 32'h20000000, 32'shFFFF0000, 32'sh0,
                                  31'h00000001, 31'h00000001, 0));
      directed_rows.push_back(row(32'h12345678, 32'hDEADBEEF, 32'sh55555555, 32'shAAAAAAAA,
                                  31'h55555555, 31'h2AAAAAAA, 0));
      foreach (directed_rows[i])
         send_star(directed_rows[i].s, directed_rows[i].typed, directed_rows[i].p);
      drain();

      // writes to undecoded indexes must leave the registers alone
      write_reg(REG_SPARE_2, 32'hFFFFFFFF);
      write_reg(REG_SPARE_3, 32'hFFFFFFFF);
      foreach (directed_rows[i])
         if (directed_rows[i].typed)
            send_star(directed_rows[i].s, 1'b1, directed_rows[i].p);
      drain();

      // register settings: small, extremes, and each disable case
      counts = '{8'd1, 8'd255, 8'd255, 8'd0, 8'd7, 8'd3};
      amps   = '{32'h00010000, 32'h00000001, 32'hFFFFFFFF, 32'h00010000, 32'h0, 32'h00008000};
      for (int ph = 0; ph < 8; ph++) begin
         if (ph < 6) begin
            write_reg(REG_PERTURB_COUNT, {24'd0, counts[ph]});
            write_reg(REG_PERTURB_AMP, amps[ph]);
         end else begin
            write_reg(REG_PERTURB_COUNT, $urandom);
            write_reg(REG_PERTURB_AMP, $urandom);
         end
         set_idling(ph);
         // perturbation corner rows under this setting
         send_star('{32'h0, 32'h0, 32'sh0, 32'sh0, 31'h7FFFFFFF, 31'h0}, 1'b0, none);
         send_star('{32'hFFFFFFFF, 32'h0, 32'sh0, 32'sh0, 31'h00000001, 31'h0}, 1'b0, none);
         for (int n = 0; n < 185; n++) begin
            s = random_star();
            send_star(s, 1'b0, none);
            if (n % 60 == 59) set_idling($urandom_range(3));
         end
         drain();
      end

      if (mismatches == 0)
         $display("PASS rotated_ellipse_star_position");
      else
         $display("FAIL rotated_ellipse_star_position");
      $finish;
   end

endmodule

// ----- rotated_ellipse_star_position.f -----
src/resp_pkg.sv
src/rotated_ellipse_star_position.sv
tb/sv/testbench.sv
